### rtl/core/ordered_list_insert_delete_search_assert.svh
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_search_assert.svh
// assertion macros for the ordered list block, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_DELETE_SEARCH_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_SEARCH_ASSERT_SVH

`ifndef SYNTH
// checked on every rising edge outside reset
`define OLIDS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked on every rising edge, reset included
`define OLIDS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OLIDS_ASSERT(lbl, clk, rstn, prop, msg)
`define OLIDS_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

### rtl/core/olids_pkg.sv
// ----------------------------------------------------------------------------
// olids_pkg
// types, codes and defaults shared by the ordered list block
// ----------------------------------------------------------------------------
`default_nettype none

package olids_pkg;

  localparam int unsigned CapacityDef   = 16;
  localparam int unsigned ValueWidthDef = 32;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned DataW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LengthW = 5;

  // operation codes
  localparam logic [FuncW-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FuncW-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FuncW-1:0] FUNC_SEARCH = 2'd2;

  // status codes
  localparam logic [StatusW-1:0] ST_OK     = 2'd0;
  localparam logic [StatusW-1:0] ST_ABSENT = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [FuncW-1:0]        func;
    logic signed [DataW-1:0] value;
  } in_t;

  typedef struct packed {
    logic [StatusW-1:0]      status;
    logic                    is_last;
    logic signed [DataW-1:0] next_value;
    logic [LengthW-1:0]      length;
  } out_t;

endpackage

`default_nettype wire

### rtl/core/olids_ram.sv
// ----------------------------------------------------------------------------
// olids_ram
// entry store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module olids_ram #(
  parameter int unsigned Depth = olids_pkg::CapacityDef,
  parameter int unsigned Width = olids_pkg::ValueWidthDef,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/olids_ctrl.sv
// ----------------------------------------------------------------------------
// olids_ctrl
// sequencer that walks the list with one comparator and compacts on delete
// ----------------------------------------------------------------------------
`default_nettype none

module olids_ctrl #(
  parameter int unsigned Capacity   = olids_pkg::CapacityDef,
  parameter int unsigned ValueWidth = olids_pkg::ValueWidthDef,
  localparam int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1,
  localparam int unsigned CntW = $clog2(Capacity + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire olids_pkg::in_t        in_data_i,
  output logic                       res_valid_o,
  input  wire logic                  res_ready_i,
  output olids_pkg::out_t            res_o,
  // entry store port
  output logic                       mem_we_o,
  output logic [IdxW-1:0]            mem_waddr_o,
  output logic [ValueWidth-1:0]      mem_wdata_o,
  output logic [IdxW-1:0]            mem_raddr_o,
  input  wire logic [ValueWidth-1:0] mem_rdata_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_NEXT  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [CntW-1:0] CapCnt = CntW'(Capacity);

  logic [2:0]                   state_q, state_d;
  logic [olids_pkg::FuncW-1:0]  op_q, op_d;
  logic [ValueWidth-1:0]        key_q, key_d;
  logic [IdxW-1:0]              idx_q, idx_d;
  logic [CntW-1:0]              count_q, count_d;
  olids_pkg::out_t              res_q, res_d;

  logic [ValueWidth+olids_pkg::DataW-1:0] key_ext;
  logic [ValueWidth+olids_pkg::DataW-1:0] rd_ext;
  logic [CntW-1:0]                        idx_p1;
  logic [CntW-1:0]                        idx_p2;
  logic                                   hit;
  logic                                   at_tail;

  // stored width may be narrower or wider than the 32-bit fields
  assign key_ext = {{ValueWidth{1'b0}}, in_data_i.value};
  assign rd_ext  = {{olids_pkg::DataW{1'b0}}, mem_rdata_i};

  assign idx_p1  = CntW'(idx_q) + CntW'(1);
  assign idx_p2  = CntW'(idx_q) + CntW'(2);
  assign hit     = (mem_rdata_i == key_q);
  assign at_tail = (idx_p1 >= count_q);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    idx_d       = idx_q;
    count_d     = count_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = idx_p1[IdxW-1:0];

    case (state_q)
      S_IDLE: begin
        mem_raddr_o = '0;
        if (in_valid_i) begin
          op_d               = in_data_i.func;
          key_d              = key_ext[ValueWidth-1:0];
          idx_d              = '0;
          res_d.status       = olids_pkg::ST_ABSENT;
          res_d.is_last      = 1'b0;
          res_d.next_value   = '0;
          res_d.length       = olids_pkg::LengthW'(count_q);
          state_d            = S_DONE;
          if (in_data_i.func == olids_pkg::FUNC_INSERT) begin
            if (count_q == CapCnt) begin
              res_d.status = olids_pkg::ST_FULL;
            end else begin
              mem_we_o     = 1'b1;
              mem_waddr_o  = count_q[IdxW-1:0];
              mem_wdata_o  = key_ext[ValueWidth-1:0];
              count_d      = count_q + CntW'(1);
              res_d.status = olids_pkg::ST_OK;
              res_d.length = olids_pkg::LengthW'(count_q + CntW'(1));
            end
          end else if ((in_data_i.func inside {olids_pkg::FUNC_DELETE,
                                                olids_pkg::FUNC_SEARCH}) &&
                       count_q != '0) begin
            state_d = S_SCAN;
          end
        end
      end

      // read data holds entry idx, read of idx+1 is issued meanwhile
      S_SCAN: begin
        if (hit) begin
          if (op_q == olids_pkg::FUNC_DELETE) begin
            state_d = S_SHIFT;
          end else if (at_tail) begin
            res_d.status  = olids_pkg::ST_OK;
            res_d.is_last = 1'b1;
            state_d       = S_DONE;
          end else begin
            state_d = S_NEXT;
          end
        end else if (at_tail) begin
          state_d = S_DONE;
        end else begin
          idx_d = idx_p1[IdxW-1:0];
        end
      end

      S_NEXT: begin
        res_d.status     = olids_pkg::ST_OK;
        res_d.next_value = rd_ext[olids_pkg::DataW-1:0];
        state_d          = S_DONE;
      end

      // move entry idx+1 down to idx until the tail
      S_SHIFT: begin
        mem_raddr_o = idx_p2[IdxW-1:0];
        if (!at_tail) begin
          mem_we_o = 1'b1;
          idx_d    = idx_p1[IdxW-1:0];
        end else begin
          count_d      = count_q - CntW'(1);
          res_d.status = olids_pkg::ST_OK;
          res_d.length = olids_pkg::LengthW'(count_q - CntW'(1));
          state_d      = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    key_q <= key_d;
    idx_q <= idx_d;
    res_q <= res_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

`default_nettype wire

### rtl/core/ordered_list_insert_delete_search.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_search
// bounded insertion-ordered list with append, delete-first and search
// ----------------------------------------------------------------------------
// Holds up to CAPACITY signed words in insertion order in a single-port-write,
// registered-read memory. One item is worked on at a time: insert writes its
// result to the result register and then the output register; search and
// delete walk the entries one per cycle through a single comparator, and
// delete then moves each later entry down one place per cycle. The
// registered memory read and the one comparator set the pace of the walk.
// A finished result sits in an output register, so the next item is taken
// while it waits for a transfer.
`default_nettype none

`include "ordered_list_insert_delete_search_assert.svh"

module ordered_list_insert_delete_search #(
  parameter int unsigned CAPACITY    = olids_pkg::CapacityDef,
  parameter int unsigned VALUE_WIDTH = olids_pkg::ValueWidthDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire olids_pkg::in_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output olids_pkg::out_t      out_data_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                   mem_we;
  logic [IdxW-1:0]        mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [IdxW-1:0]        mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_rdata;

  logic                   res_valid;
  logic                   res_ready;
  olids_pkg::out_t        res;

  logic                   out_valid_q;
  olids_pkg::out_t        out_data_q;

  olids_ram #(
    .Depth (CAPACITY),
    .Width (VALUE_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  olids_ctrl #(
    .Capacity   (CAPACITY),
    .ValueWidth (VALUE_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // output slot frees up in the same cycle as its transfer
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `OLIDS_ASSERT(a_full_len, clk_i, rst_ni, out_valid_o && out_data_o.status == olids_pkg::ST_FULL |-> out_data_o.length == olids_pkg::LengthW'(CAPACITY), "full status with wrong length")
  `OLIDS_ASSERT(a_last_ok, clk_i, rst_ni, out_valid_o && out_data_o.is_last |-> out_data_o.status == olids_pkg::ST_OK && out_data_o.next_value == '0, "tail flag on a miss or with a successor")
  `OLIDS_ASSERT(a_busy, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "input taken while an item is in progress")
  `OLIDS_ASSERT_NR(a_rst_quiet, clk_i, !rst_ni |=> !out_valid_o && in_ready_o, "not idle during reset")

endmodule

`default_nettype wire
